>>> hw/rtl/rfc_pkg.sv
// Package for the range flip/count block: word geometry, sequencer states
// and the span control struct shared by the word unit and the top level.
// No dependencies.
package rfc_pkg;

  localparam int WORD_BITS = 32;
  localparam int OFF_BITS = 5;
  localparam int DEFAULT_MAX_CELLS = 1024;
  localparam logic [10:0] CELL_COUNT_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PROC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OFF_BITS-1:0] lo_off;
    logic [OFF_BITS-1:0] hi_off;
  } span_t;

endpackage

>>> hw/rtl/rfc_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module rfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/rfc_word_unit.sv
// Shared word unit: masks one stored word to a cell span, counts set cells
// in the span and forms the flipped word. Depends on rfc_pkg.
module rfc_word_unit (
  input  logic [rfc_pkg::WORD_BITS-1:0] word,
  input  rfc_pkg::span_t                span,
  output logic [rfc_pkg::WORD_BITS-1:0] flipped,
  output logic [rfc_pkg::OFF_BITS:0]    pop
);

  logic [rfc_pkg::WORD_BITS-1:0] mask;
  logic [rfc_pkg::WORD_BITS-1:0] hit;
  logic [3:0]                    nib [8];

  always_comb begin
    mask = ({rfc_pkg::WORD_BITS{1'b1}} << span.lo_off) &
           ({rfc_pkg::WORD_BITS{1'b1}} >> (5'd31 - span.hi_off));
    hit = word & mask;
    flipped = word ^ mask;
    for (int i = 0; i < 8; i++) begin
      nib[i] = {3'b0, hit[4*i]} + {3'b0, hit[4*i+1]} +
               {3'b0, hit[4*i+2]} + {3'b0, hit[4*i+3]};
    end
    pop = 6'({2'b0, nib[0]} + {2'b0, nib[1]} + {2'b0, nib[2]} + {2'b0, nib[3]} +
             {2'b0, nib[4]} + {2'b0, nib[5]} + {2'b0, nib[6]} + {2'b0, nib[7]});
  end

endmodule

>>> hw/rtl/range_flip_count_segment_tree.sv
// Top level: range flip / range count over a row of binary cells.
// Depends on rfc_pkg, rfc_ram, rfc_word_unit.
//
//  channel   | dir | fields (low bit up)
//  s_*       | in  | tdata: range_start[9:0], range_end[19:10]; tuser: cmd
//  m_*       | out | tdata: set_count[10:0]
//  cfg_*     | in  | cell_count[10:0]
//
// Cells are packed 32 to a RAM word; through the single RAM port each word
// of the clipped range is read in ST_READ and processed in ST_PROC, a flip
// writing the flipped word back.
// Reset and each cell_count write run a clearing pass over all
// ceil(MAX_CELLS/32) words; no request is taken meanwhile. A waiting result
// does not block new requests until the next count needs the output register.
module range_flip_count_segment_tree #(
  parameter int MAX_CELLS = rfc_pkg::DEFAULT_MAX_CELLS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // range_start[9:0], range_end[19:10]
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // set_count[10:0]
);

  localparam int DEPTH = (MAX_CELLS + rfc_pkg::WORD_BITS - 1) / rfc_pkg::WORD_BITS;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam logic [16:0] MAXV = 17'(MAX_CELLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  rfc_pkg::state_t state, state_next;

  logic [10:0]   cell_count;
  logic [AW-1:0] clr_addr;
  logic [4:0]    word;
  logic [9:0]    lo, hi;
  logic          is_count;
  logic [10:0]   total;
  logic          out_valid;
  logic [10:0]   out_data;

  logic [16:0] n17, bclip17;
  logic        req_ok;
  logic [15:0] word_ext;
  logic [AW-1:0] ram_addr;
  logic        ram_we;
  logic [31:0] ram_wdata, ram_rdata;
  rfc_pkg::span_t span;
  logic [31:0] flipped;
  logic [5:0]  pop;
  logic        accept;

  assign accept = s_tvalid && s_tready;
  assign s_tready = (state == rfc_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata = {5'b0, out_data};

  always_comb begin
    n17 = ({6'b0, cell_count} > MAXV) ? MAXV : {6'b0, cell_count};
    bclip17 = ({7'b0, s_tdata[19:10]} > n17 - 17'd1) ? n17 - 17'd1 : {7'b0, s_tdata[19:10]};
    req_ok = (n17 != 17'd0) && ({7'b0, s_tdata[9:0]} <= bclip17);
  end

  assign word_ext = {11'b0, word};
  assign span.lo_off = (word == lo[9:5]) ? lo[4:0] : 5'd0;
  assign span.hi_off = (word == hi[9:5]) ? hi[4:0] : 5'd31;

  rfc_word_unit u_word (
    .word    (ram_rdata),
    .span    (span),
    .flipped (flipped),
    .pop     (pop)
  );

  always_comb begin
    ram_addr = word_ext[AW-1:0];
    ram_we = 1'b0;
    ram_wdata = flipped;
    if (state == rfc_pkg::ST_CLEAR) begin
      ram_addr = clr_addr;
      ram_we = 1'b1;
      ram_wdata = '0;
    end else if (state == rfc_pkg::ST_PROC && !is_count) begin
      ram_we = 1'b1;
    end
  end

  rfc_ram #(
    .WIDTH (rfc_pkg::WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rfc_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = rfc_pkg::ST_IDLE;
      end
      rfc_pkg::ST_IDLE: begin
        if (accept) state_next = req_ok ? rfc_pkg::ST_READ : rfc_pkg::ST_DONE;
      end
      rfc_pkg::ST_READ: state_next = rfc_pkg::ST_PROC;
      rfc_pkg::ST_PROC: begin
        state_next = (word == hi[9:5]) ? rfc_pkg::ST_DONE : rfc_pkg::ST_READ;
      end
      rfc_pkg::ST_DONE: begin
        if (!is_count || !out_valid || m_tready) state_next = rfc_pkg::ST_IDLE;
      end
      default: state_next = rfc_pkg::ST_IDLE;
    endcase
    if (cfg_wr_en) state_next = rfc_pkg::ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfc_pkg::ST_CLEAR;
      cell_count <= rfc_pkg::CELL_COUNT_RESET;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        cell_count <= cfg_wr_data;
        clr_addr <= '0;
      end else if (state == rfc_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == rfc_pkg::ST_DONE && is_count && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_count <= s_tuser;
      lo <= s_tdata[9:0];
      hi <= bclip17[9:0];
      word <= s_tdata[9:5];
      total <= '0;
    end else if (state == rfc_pkg::ST_PROC) begin
      total <= total + {5'b0, pop};
      if (word != hi[9:5]) word <= word + 5'd1;
    end
    if (state == rfc_pkg::ST_DONE && is_count && (!out_valid || m_tready)) begin
      out_data <= total;
    end
  end

endmodule
